/* sv/prd_pkg.sv */
// Package for the priority ring deque: shared codes, controller states,
// the controller-to-datapath command struct and the default depth.
// No dependencies; every other file of the block imports it.
`default_nettype none

package prd_pkg;

    localparam int DEPTH_DEFAULT = 8;

    // Field widths fixed by the stream payload
    localparam int BYTE_W   = 8;
    localparam int ENTRY_W  = BYTE_W + 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // Request kind carried on the input tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status carried on the output tuser
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;   // capture the accepted request
        logic exec;   // apply it to the ring and the entry memory
    } t_dp_cmd;

endpackage

`default_nettype wire

/* sv/prd_ctrl.sv */
// Controller of the priority ring deque: sequences one request through
// capture, execute and respond. Depends on prd_pkg.
`default_nettype none

module prd_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_ready,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output prd_pkg::t_dp_cmd     o_cmd
);
    import prd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/prd_dpath.sv */
// Datapath of the priority ring deque: request register, front/back
// pointers, occupancy, entry memory and result registers.
// Depends on prd_pkg; driven by prd_ctrl commands.
`default_nettype none

module prd_dpath #(
    parameter int DEPTH = prd_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire prd_pkg::t_dp_cmd              i_cmd,
    input  wire logic                          i_op,
    input  wire logic                          i_urgent,
    input  wire logic                          i_sender,
    input  wire logic [prd_pkg::BYTE_W-1:0]    i_byte,
    output logic      [prd_pkg::STATUS_W-1:0]  o_status,
    output logic                               o_urgent,
    output logic                               o_sender,
    output logic      [prd_pkg::BYTE_W-1:0]    o_byte,
    output logic      [prd_pkg::COUNT_W-1:0]   o_fill_count
);
    import prd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [ENTRY_W-1:0] mem [DEPTH];

    logic               r_op;
    logic               r_urgent;
    logic               r_sender;
    logic [BYTE_W-1:0]  r_byte;

    logic [PTR_W-1:0]   r_front, n_front;
    logic [PTR_W-1:0]   r_back,  n_back;
    logic [CNT_W-1:0]   r_occ,   n_occ;

    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_pop_ok, n_pop_ok;
    logic [ENTRY_W-1:0]  r_rd_data;

    logic               push_ok;
    logic [PTR_W-1:0]   front_inc;
    logic [PTR_W-1:0]   front_dec;
    logic [PTR_W-1:0]   back_inc;
    logic [PTR_W-1:0]   wr_addr;
    logic [31:0]        occ_ext;

    assign front_inc = (r_front == PTR_LAST) ? '0 : r_front + 1'b1;
    assign front_dec = (r_front == '0) ? PTR_LAST : r_front - 1'b1;
    assign back_inc  = (r_back == PTR_LAST) ? '0 : r_back + 1'b1;
    assign wr_addr   = r_urgent ? front_dec : r_back;

    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_occ    = r_occ;
        n_status = ST_DONE;
        n_pop_ok = 1'b0;
        push_ok  = 1'b0;
        if (r_op == OP_PUSH) begin
            if (r_occ == CNT_FULL) begin
                n_status = ST_FULL;
            end else begin
                push_ok = 1'b1;
                n_occ   = r_occ + 1'b1;
                if (r_urgent) begin
                    n_front = front_dec;
                end else begin
                    n_back = back_inc;
                end
            end
        end else begin
            if (r_occ == '0) begin
                n_status = ST_EMPTY;
            end else begin
                n_pop_ok = 1'b1;
                n_occ    = r_occ - 1'b1;
                n_front  = front_inc;
            end
        end
    end

    // Hold the accepted request for the execute cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_urgent <= i_urgent;
            r_sender <= i_sender;
            r_byte   <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_back   <= '0;
            r_occ    <= '0;
            r_status <= ST_DONE;
            r_pop_ok <= 1'b0;
        end else if (i_cmd.exec) begin
            r_front  <= n_front;
            r_back   <= n_back;
            r_occ    <= n_occ;
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    // Entry memory: one write port, one registered read port at the front
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && push_ok) begin
            mem[wr_addr] <= {r_urgent, r_sender, r_byte};
        end
        if (i_cmd.exec) begin
            r_rd_data <= mem[r_front];
        end
    end

    assign occ_ext      = 32'(r_occ);
    assign o_status     = r_status;
    assign o_urgent     = r_pop_ok & r_rd_data[ENTRY_W-1];
    assign o_sender     = r_pop_ok & r_rd_data[ENTRY_W-2];
    assign o_byte       = r_pop_ok ? r_rd_data[BYTE_W-1:0] : '0;
    assign o_fill_count = occ_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

/* sv/priority_ring_deque.sv */
// Top level of the priority ring deque: stream ports, controller and datapath.
// Depends on prd_pkg, prd_ctrl and prd_dpath.
//
//   channel  direction  tuser            tdata (lowest bit up)
//   s_axis   in         op               urgent, sender, message_byte, zero pad
//   m_axis   out        status           out_urgent, out_sender, out_byte,
//                                        fill_count, zero pad
//
// Each request passes through capture, then execute (memory write or
// registered front read plus pointer update), then the result is offered.
// The next request is taken only once the result has been handed off, and
// any time m_axis_tready is low holds the next request back.
// Synchronous reset empties the ring at once; entry memory is not cleared.
`default_nettype none

module priority_ring_deque #(
    parameter int DEPTH = prd_pkg::DEPTH_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // urgent, sender, message_byte[7:0], zero pad
    input  wire logic [prd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // op
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // out_urgent, out_sender, out_byte[7:0], fill_count[3:0], zero pad
    output logic      [prd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status[1:0]
    output logic      [prd_pkg::STATUS_W-1:0]       m_axis_tuser
);
    import prd_pkg::*;

    localparam int OUT_USED_W = BYTE_W + 2 + COUNT_W;

    t_dp_cmd              cmd;
    logic                 out_urgent;
    logic                 out_sender;
    logic [BYTE_W-1:0]    out_byte;
    logic [COUNT_W-1:0]   fill_count;

    prd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    prd_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (s_axis_tuser),
        .i_urgent     (s_axis_tdata[0]),
        .i_sender     (s_axis_tdata[1]),
        .i_byte       (s_axis_tdata[BYTE_W+1:2]),
        .o_status     (m_axis_tuser),
        .o_urgent     (out_urgent),
        .o_sender     (out_sender),
        .o_byte       (out_byte),
        .o_fill_count (fill_count)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                           fill_count, out_byte, out_sender, out_urgent};

endmodule

`default_nettype wire

/* sim/prd_checker.sv */
// Scoreboard for the priority ring deque: watches both stream channels,
// tracks the ring contents and checks every result against its prediction.
// Depends on prd_pkg for widths, request kinds and status codes.
`timescale 1ns / 1ps

module prd_checker #(
    parameter int DEPTH = prd_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // urgent, sender, message_byte[7:0], zero pad
    input  logic [prd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // op
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_urgent, out_sender, out_byte[7:0], fill_count[3:0], zero pad
    input  logic [prd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // status[1:0]
    input  logic [prd_pkg::STATUS_W-1:0]        m_axis_tuser,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import prd_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                urgent;
        logic                sender;
        logic [BYTE_W-1:0]   chr;
        logic [COUNT_W-1:0]  fill;
    } deque_result_t;

    deque_result_t      expected_results[$];
    logic [ENTRY_W-1:0] ring_slots[DEPTH];
    int                 front_slot;
    int                 back_slot;
    int                 held_msgs;
    int                 result_idx;

    initial o_fail_count = 0;
    initial o_pending = 0;

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("MISMATCH t=%0t result %0d: %s = %0h, expected %0h",
                 $time, result_idx, field, got, want);
        o_fail_count++;
    endtask

    // Apply one request to the shadow ring and return the result it causes.
    function automatic deque_result_t apply_request(input logic op, input logic urg,
                                                    input logic snd,
                                                    input logic [BYTE_W-1:0] chr);
        deque_result_t r;
        int            slot;
        r = '0;
        r.status = ST_DONE;
        if (op == OP_PUSH) begin
            if (held_msgs >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                if (urg) begin
                    front_slot = (front_slot == 0) ? DEPTH - 1 : front_slot - 1;
                    slot = front_slot;
                end else begin
                    slot = back_slot;
                    back_slot = (back_slot + 1 >= DEPTH) ? 0 : back_slot + 1;
                end
                ring_slots[slot] = {urg, snd, chr};
                held_msgs++;
            end
        end else begin
            if (held_msgs == 0) begin
                r.status = ST_EMPTY;
            end else begin
                {r.urgent, r.sender, r.chr} = ring_slots[front_slot];
                front_slot = (front_slot + 1 >= DEPTH) ? 0 : front_slot + 1;
                held_msgs--;
            end
        end
        r.fill = held_msgs[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        deque_result_t want;
        if (!i_rst_n) begin
            front_slot = 0;
            back_slot = 0;
            held_msgs = 0;
            result_idx = 0;
            expected_results.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(apply_request(s_axis_tuser, s_axis_tdata[0],
                                                         s_axis_tdata[1],
                                                         s_axis_tdata[9:2]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result tdata", int'(m_axis_tdata), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser != want.status)
                        report_mismatch("status", int'(m_axis_tuser), int'(want.status));
                    if (m_axis_tdata[0] != want.urgent)
                        report_mismatch("out_urgent", int'(m_axis_tdata[0]),
                                        int'(want.urgent));
                    if (m_axis_tdata[1] != want.sender)
                        report_mismatch("out_sender", int'(m_axis_tdata[1]),
                                        int'(want.sender));
                    if (m_axis_tdata[9:2] != want.chr)
                        report_mismatch("out_byte", int'(m_axis_tdata[9:2]),
                                        int'(want.chr));
                    if (m_axis_tdata[13:10] != want.fill)
                        report_mismatch("fill_count", int'(m_axis_tdata[13:10]),
                                        int'(want.fill));
                end
                result_idx++;
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

/* sim/tb_top.sv */
// Testbench top for the priority ring deque: clock, reset, request stimulus
// with random idling on both channels, and the final verdict.
// Depends on prd_pkg, priority_ring_deque and prd_checker.
`timescale 1ns / 1ps

module tb_top;
    import prd_pkg::*;

    localparam int N_RANDOM    = 1600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 12;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = OP_PUSH;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    int   fail_count;
    int   pending;
    int   cycles = 0;
    logic no_idle = 1'b0;

    priority_ring_deque dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    prd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("priority_ring_deque verification failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none in quiet stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_request(input logic op, input logic urg, input logic snd,
                                input logic [BYTE_W-1:0] chr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_TDATA_W - BYTE_W - 2){1'b0}}, chr, snd, urg};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_pop();
        send_request(OP_POP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
    endtask

    // Result side: stall in random bursts.
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    initial begin
        int sent;
        int phase_len;
        int pop_pct;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pop, both push kinds, wrap, full ring, drain.
        send_pop();
        send_request(OP_PUSH, 1'b0, 1'b0, 8'h00);
        send_request(OP_PUSH, 1'b1, 1'b1, 8'hFF);
        send_pop();
        send_pop();
        send_pop();
        for (int i = 0; i < DEPTH_DEFAULT; i++)
            send_request(OP_PUSH, i[0], i[1], (i[0] ? 8'hAA : 8'h55) ^ i[7:0]);
        send_request(OP_PUSH, 1'b0, 1'b1, 8'h81);
        send_request(OP_PUSH, 1'b1, 1'b0, 8'h7E);
        for (int i = 0; i < DEPTH_DEFAULT; i++)
            send_pop();
        send_pop();

        // Random: phases that lean toward filling, draining or balance.
        sent = 0;
        while (sent < N_RANDOM) begin
            phase_len = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
                0: pop_pct = 15;
                1: pop_pct = 50;
                default: pop_pct = 85;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len && sent < N_RANDOM; i++) begin
                send_request(($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_PUSH,
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)));
                sent++;
            end
        end
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;

        // Step first so the last request shows up in the pending count
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("priority_ring_deque verification clean");
        else
            $display("priority_ring_deque verification failed");
        $finish;
    end

endmodule
